// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of the tracking controller.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define STC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// When cond holds, expr must hold on the following clock edge.
`define STC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== src/stc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the sidereal tracking controller.
// Used by every module of the block; depends on nothing.
package stc_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned IntervalW = 24;
  localparam int unsigned DividendW = TimeW + 1;
  localparam int unsigned DivCntW   = $clog2(DividendW);
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 72;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [SampleW-1:0]   ThresholdReset = 10'd512;
  localparam logic [IntervalW-1:0] IntervalReset  = 24'd414250;

  // Register index taken from the word address.
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_INTERVAL  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    DRIVE_OFF   = 2'd0,
    DRIVE_PLUS  = 2'd1,
    DRIVE_MINUS = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    DELTA_NONE = 2'd0,
    DELTA_INC  = 2'd1,
    DELTA_DEC  = 2'd2
  } delta_t;

  typedef struct packed {
    logic [SampleW-1:0]   threshold;
    logic [IntervalW-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [IntervalW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quotient;
    logic [IntervalW-1:0] remainder;
  } div_rsp_t;

  // Quadrature transition table. A jump where both channels flip is illegal
  // and moves nothing.
  function automatic delta_t quad_step(input logic [1:0] prev, input logic [1:0] cur);
    delta_t d;
    case ({prev, cur})
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: d = DELTA_INC;
      4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: d = DELTA_DEC;
      default:                                d = DELTA_NONE;
    endcase
    return d;
  endfunction

endpackage

// ===== src/stc_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers of the tracking controller behind an APB-style port.
// Depends on stc_pkg.
module stc_regs
  import stc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output cfg_t                cfg
);

  logic [SampleW-1:0]   threshold_r;
  logic [IntervalW-1:0] interval_r;
  logic                 wr_en;
  reg_idx_t             idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= ThresholdReset;
      interval_r  <= IntervalReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD: threshold_r <= pwdata[SampleW-1:0];
        REG_INTERVAL:  interval_r  <= pwdata[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = {{(CfgDataW-SampleW){1'b0}}, threshold_r};
      REG_INTERVAL:  prdata = {{(CfgDataW-IntervalW){1'b0}}, interval_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.threshold = threshold_r;
  assign cfg.interval  = interval_r;

endmodule

// ===== src/stc_divider.sv =====
`timescale 1ns / 1ps
// Restoring radix-2 divider: 33-bit dividend by 24-bit divisor, one bit a cycle.
// Depends on stc_pkg.
module stc_divider
  import stc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DivCntW-1:0]   cnt_r;
  logic [IntervalW-1:0] rem_r;
  logic [DividendW-1:0] quo_r;
  logic [IntervalW-1:0] div_r;
  logic [IntervalW+1:0] trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {1'b0, rem_r, quo_r[DividendW-1]} - {2'b00, div_r};
  assign fits  = !trial[IntervalW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
      cnt_r <= DivCntW'(DividendW - 1);
    end else if (busy_r) begin
      rem_r <= fits ? trial[IntervalW-1:0] : {rem_r[IntervalW-2:0], quo_r[DividendW-1]};
      quo_r <= {quo_r[DividendW-2:0], fits};
      cnt_r <= cnt_r - DivCntW'(1);
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== src/sidereal_tracking_controller.sv =====
`timescale 1ns / 1ps
// Sidereal tracking controller: quadrature decode, time-based reference count,
// bang-bang drive. Uses stc_pkg, stc_regs and stc_divider.
//
// Input stream (in_*): one item per encoder sample, two raw channel samples
// and a microsecond timestamp. Output stream (out_*): exactly one item per
// input item with drive, reference-minus-position error and position in
// tdata, and the phase-changed flag in tuser. Configuration goes through the
// APB-style cfg_* port and must be written only while the block is idle; the
// block itself does not enforce this. An item without a phase change goes
// from ST_IDLE to ST_DONE, then into the output register once it is free; one
// with a phase change passes ST_SUM to start the restoring divider on the
// 33-bit time sum, ST_DIV until its quotient is done, ST_UPD to update the
// reference and ST_DONE to load the result. in_tready is high only while the
// block is idle, so no new item is accepted before the last one is loaded.
// A finished result waits in the output register while the next item is
// accepted; if the receiver still stalls when that next item finishes, the
// block holds it until the register frees up.
// Synchronous reset clears position, reference, time state and drive (off)
// and restores the register defaults.
module sidereal_tracking_controller
  import stc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [9:0] sample_a, [19:10] sample_b, [51:20] time_us, [55:52] zero
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [1:0] drive, [33:2] error_steps, [65:34] position, [71:66] zero
  output logic [OutDataW-1:0] out_tdata,
  // [0] phase_changed
  output logic                out_tuser,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  cfg_t                 cfg;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic [1:0]           last_phase_r;
  logic [CountW-1:0]    pos_r;
  logic [CountW-1:0]    ref_r;
  logic [IntervalW-1:0] rem_r;
  logic [TimeW-1:0]     last_t_r;
  logic [TimeW-1:0]     elapsed_r;
  logic [CountW-1:0]    quo_r;
  drive_t               drive_r, drive_nxt;
  logic                 changed_r;
  logic                 out_valid_r;
  logic [OutDataW-1:0]  out_data_r;
  logic                 out_user_r;

  logic [SampleW-1:0]   smp_a, smp_b;
  logic [TimeW-1:0]     smp_t;
  logic [1:0]           phase;
  delta_t               delta;
  logic                 in_fire;
  logic                 out_load;
  logic [CountW-1:0]    err;

  stc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  stc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_pready = 1'b1;

  assign smp_a = in_tdata[SampleW-1:0];
  assign smp_b = in_tdata[2*SampleW-1:SampleW];
  assign smp_t = in_tdata[2*SampleW+TimeW-1:2*SampleW];
  assign phase = {smp_a > cfg.threshold, smp_b > cfg.threshold};
  assign delta = quad_step(last_phase_r, phase);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // The remainder is always below 2^24, so the sum fits 33 bits.
  assign div_req.start    = (state_r == ST_SUM);
  assign div_req.dividend = {{(DividendW-IntervalW){1'b0}}, rem_r}
                          + {1'b0, elapsed_r};
  assign div_req.divisor  = (cfg.interval == '0) ? IntervalW'(1) : cfg.interval;

  assign err = ref_r - pos_r;

  // Bang-bang rule; an error of plus or minus one keeps the current drive.
  always_comb begin
    drive_nxt = drive_r;
    if (changed_r) begin
      if (err == '0) begin
        drive_nxt = DRIVE_OFF;
      end else if (err[CountW-1] && (err != '1)) begin
        drive_nxt = DRIVE_PLUS;
      end else if (!err[CountW-1] && (err != CountW'(1))) begin
        drive_nxt = DRIVE_MINUS;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = (phase != last_phase_r) ? ST_SUM : ST_DONE;
      ST_SUM:  state_nxt = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_phase_r <= 2'b00;
      pos_r        <= '0;
      ref_r        <= '0;
      rem_r        <= '0;
      last_t_r     <= '0;
      drive_r      <= DRIVE_OFF;
      changed_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        last_phase_r <= phase;
        changed_r    <= (phase != last_phase_r);
        if (delta == DELTA_INC) begin
          pos_r <= pos_r + CountW'(1);
        end else if (delta == DELTA_DEC) begin
          pos_r <= pos_r - CountW'(1);
        end
        if (phase != last_phase_r) begin
          last_t_r <= smp_t;
        end
      end
      if ((state_r == ST_DIV) && div_rsp.done) begin
        rem_r <= div_rsp.remainder;
      end
      if (state_r == ST_UPD) begin
        ref_r <= ref_r + quo_r;
      end
      if (out_load) begin
        drive_r     <= drive_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      elapsed_r <= smp_t - last_t_r;
    end
    if ((state_r == ST_DIV) && div_rsp.done) begin
      quo_r <= div_rsp.quotient[CountW-1:0];
    end
    if (out_load) begin
      out_data_r <= {{(OutDataW-2*CountW-2){1'b0}}, pos_r, err, drive_nxt};
      out_user_r <= changed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/stc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the tracking controller, bound to the top level.
// Depends on stc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stc_checker
  import stc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tuser,
  input logic                cfg_pready
);

  // The block works on one item at a time.
  `STC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted while busy")

  // A stalled result keeps its payload.
  `STC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  `STC_ASSERT(a_drive_code, clk, rst_n, !out_tvalid || (out_tdata[1:0] == DRIVE_OFF) || (out_tdata[1:0] == DRIVE_PLUS) || (out_tdata[1:0] == DRIVE_MINUS), "bad drive code")

  `STC_ASSERT(a_pready, clk, rst_n, cfg_pready, "configuration port not ready")

endmodule

bind sidereal_tracking_controller stc_checker u_stc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

// ===== tb/sv/sidereal_tracking_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sidereal tracking controller: directed and random encoder
// samples go in through the in_ stream, and each result item is checked against a local model.
// Depends on stc_pkg and the sidereal_tracking_controller RTL only.
module sidereal_tracking_controller_tb;
  import stc_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 2000;

  typedef struct {
    logic [9:0]  a;
    logic [9:0]  b;
    logic [31:0] stamp;
    int          gap;
  } sample_t;

  typedef struct {
    drive_t      drive;
    logic [31:0] err;
    logic [31:0] pos;
    logic        changed;
  } track_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  sidereal_tracking_controller u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Configuration and tracking state of the local model.
  logic [9:0]  cfg_thr = ThresholdReset;
  logic [23:0] cfg_ivl = IntervalReset;
  logic [1:0]  trk_phase = 2'd0;
  logic [31:0] trk_pos = '0;
  logic [31:0] trk_ref = '0;
  logic [31:0] trk_rem = '0;
  logic [31:0] trk_last_t = '0;
  drive_t      trk_drive = DRIVE_OFF;

  sample_t sample_q[$];
  track_t  track_results_q[$];

  // Generator state: phase and timestamp of the last queued sample.
  logic [1:0]  gen_phase = 2'd0;
  logic [31:0] gen_time = '0;
  bit          in_busy = 1'b1;
  bit          rx_busy = 1'b1;
  int          n_queued = 0;

  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  int rx_wait = 0;
  int in_gap_left = -1;

  int cycle_count = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int n_changes = 0;
  int n_cfg_writes = 0;
  int drive_seen[3] = '{0, 0, 0};

  function automatic track_t track_step(input logic [9:0] a, input logic [9:0] b,
                                        input logic [31:0] stamp);
    logic [1:0]         ph;
    logic [1:0]         gray_move;
    logic [23:0]        ivl;
    logic [32:0]        span_sum;
    logic signed [31:0] e;
    track_t             r;
    ph = {a > cfg_thr, b > cfg_thr};
    // Position in the Gray sequence 00, 01, 11, 10: a move of +1 is forward, -1 backward,
    // and 2 is a jump where both channels flip, which does not move the count.
    gray_move = {ph[1], ^ph} - {trk_phase[1], ^trk_phase};
    if (gray_move == 2'd1) trk_pos = trk_pos + 32'd1;
    else if (gray_move == 2'd3) trk_pos = trk_pos - 32'd1;
    r.changed = (ph != trk_phase);
    if (r.changed) begin
      ivl = (cfg_ivl == 24'd0) ? 24'd1 : cfg_ivl;
      span_sum = {1'b0, trk_rem} + {1'b0, stamp - trk_last_t};
      trk_ref = trk_ref + 32'(span_sum / ivl);
      trk_rem = 32'(span_sum % ivl);
      trk_last_t = stamp;
      e = trk_ref - trk_pos;
      if (e < -1) trk_drive = DRIVE_PLUS;
      else if (e > 1) trk_drive = DRIVE_MINUS;
      else if (e == 0) trk_drive = DRIVE_OFF;
    end
    trk_phase = ph;
    r.drive = trk_drive;
    r.err = trk_ref - trk_pos;
    r.pos = trk_pos;
    return r;
  endfunction

  // A sample that reads high or low under the current threshold, now and then right on it.
  function automatic logic [9:0] level_sample(input logic hi);
    logic [9:0] v;
    if (hi && cfg_thr != 10'd1023) begin
      v = ($urandom_range(7, 0) == 0) ? cfg_thr + 10'd1
                                      : 10'($urandom_range(1023, cfg_thr + 1));
    end else if (hi) begin
      v = 10'd1023;
    end else begin
      v = ($urandom_range(7, 0) == 0) ? cfg_thr : 10'($urandom_range(cfg_thr, 0));
    end
    return v;
  endfunction

  function automatic logic [1:0] step_phase(input logic [1:0] p, input int steps);
    logic [1:0] g;
    g = {p[1], ^p} + 2'(steps);
    return {g[1], ^g};
  endfunction

  function automatic void add_sample(input logic [9:0] a, input logic [9:0] b,
                                     input logic [31:0] stamp);
    sample_t s;
    if (n_queued % 50 == 0) in_busy = $urandom_range(1, 0);
    s.a = a;
    s.b = b;
    s.stamp = stamp;
    s.gap = in_busy ? $urandom_range(19, 0) : 0;
    sample_q.push_back(s);
    n_queued++;
    gen_phase = {a > cfg_thr, b > cfg_thr};
    gen_time = stamp;
  endfunction

  function automatic void add_phase(input logic [1:0] p, input logic [31:0] stamp);
    add_sample(level_sample(p[1]), level_sample(p[0]), stamp);
  endfunction

  // Mostly legal quadrature walks with timestamps spaced dt_lo to dt_hi apart, plus illegal
  // jumps, repeated phases and samples with fully random content.
  function automatic void add_random_run(input int n, input int unsigned dt_lo,
                                         input int unsigned dt_hi);
    int          kind;
    logic [31:0] stamp;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99, 0);
      stamp = gen_time + $urandom_range(dt_hi, dt_lo);
      if (kind < 55) add_phase(step_phase(gen_phase, 1), stamp);
      else if (kind < 75) add_phase(step_phase(gen_phase, -1), stamp);
      else if (kind < 85) add_phase(gen_phase, stamp);
      else if (kind < 92) add_phase(step_phase(gen_phase, 2), stamp);
      else add_sample(10'($urandom), 10'($urandom), $urandom);
    end
  endfunction

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_THRESHOLD) cfg_thr = value[9:0];
    else cfg_ivl = value[23:0];
    n_cfg_writes++;
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_tvalid || track_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: waits out each item's gap, then holds the item until it is taken.
  always @(negedge clk) begin : sender
    logic    nv;
    sample_t s;
    nv = in_tvalid;
    if (in_took) begin
      in_took = 1'b0;
      nv = 1'b0;
    end
    if (rst_n && !nv && sample_q.size() != 0) begin
      if (in_gap_left < 0) in_gap_left = sample_q[0].gap;
      if (in_gap_left == 0) begin
        s = sample_q.pop_front();
        in_tdata <= {4'b0, s.stamp, s.b, s.a};
        nv = 1'b1;
        in_gap_left = -1;
      end else begin
        in_gap_left--;
      end
    end
    in_tvalid <= nv;
  end

  // Receiver: stalls a random number of cycles after each result, or for one long stretch.
  always @(negedge clk) begin : receiver
    logic rdy;
    if (out_took) begin
      out_took = 1'b0;
      if (n_results % 40 == 0) rx_busy = $urandom_range(1, 0);
      rx_wait = rx_busy ? $urandom_range(19, 0) : 0;
    end
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rdy = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_tready <= rdy;
  end

  always @(posedge clk) begin : monitor
    track_t     want;
    drive_t     got_drive;
    logic [31:0] got_err;
    logic [31:0] got_pos;
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               track_results_q.size());
      $display("** sidereal_tracking_controller: FAILED **");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_took = 1'b1;
        n_results++;
        got_drive = drive_t'(out_tdata[1:0]);
        got_err = out_tdata[33:2];
        got_pos = out_tdata[65:34];
        if (got_drive <= DRIVE_MINUS) drive_seen[got_drive]++;
        if (track_results_q.size() == 0) begin
          $error("result item with no sample waiting for one");
          mismatches++;
        end else begin
          want = track_results_q.pop_front();
          if (got_drive !== want.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, got_drive);
            mismatches++;
          end
          if (got_err !== want.err) begin
            $error("error_steps: expected %0d, actual %0d", $signed(want.err), $signed(got_err));
            mismatches++;
          end
          if (got_pos !== want.pos) begin
            $error("position: expected %0d, actual %0d", $signed(want.pos), $signed(got_pos));
            mismatches++;
          end
          if (out_tuser !== want.changed) begin
            $error("phase_changed: expected %0b, actual %0b", want.changed, out_tuser);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        n_items++;
        want = track_step(in_tdata[9:0], in_tdata[19:10], in_tdata[51:20]);
        if (want.changed) n_changes++;
        track_results_q.push_back(want);
      end
    end
  end

  initial begin : stimulus
    int mark;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed samples under the reset register values.
    add_sample(10'd0, 10'd0, 32'd0);
    add_sample(10'd1023, 10'd1023, 32'd1000);       // both channels flip at once
    add_sample(10'd513, 10'd512, gen_time + 32'd414250);  // just above and right on the threshold
    add_sample(10'd512, 10'd513, gen_time + 32'd414250);  // another illegal jump
    for (int i = 0; i < 6; i++) add_phase(step_phase(gen_phase, 1), gen_time + 32'd414250);
    for (int i = 0; i < 4; i++) add_phase(step_phase(gen_phase, -1), gen_time + 32'd414250);
    add_phase(gen_phase, gen_time + 32'd5);
    add_phase(step_phase(gen_phase, 1), gen_time);  // change at the same timestamp as the previous sample
    add_phase(step_phase(gen_phase, 1), 32'hFFFF_FFF0);
    add_phase(step_phase(gen_phase, 1), 32'h0000_0010);  // timestamp wraps
    add_phase(step_phase(gen_phase, -1), 32'hFFFF_FFFF);
    add_sample(10'd1023, 10'd0, 32'd3);
    add_sample(10'd0, 10'd1023, 32'd2_000_000);
    wait_idle();

    cfg_write(REG_THRESHOLD, 32'd300);
    cfg_write(REG_INTERVAL, 32'd100);
    mark = n_results;
    add_random_run(350, 50, 150);
    // Long receiver stall while the sender keeps offering items.
    wait (n_results >= mark + 30);
    @(negedge clk);
    rx_hold_req = 1'b1;
    wait_idle();

    // Upper bits of the write are outside the threshold register.
    cfg_write(REG_THRESHOLD, 32'hFFFF_FC00);
    cfg_write(REG_INTERVAL, 32'd1);
    add_random_run(150, 0, 3);
    wait_idle();

    cfg_write(REG_THRESHOLD, 32'd1023);
    cfg_write(REG_INTERVAL, 32'd16777215);
    add_random_run(40, 0, 100_000);
    wait_idle();

    cfg_write(REG_THRESHOLD, 32'd700);
    add_random_run(200, 8_000_000, 25_000_000);
    wait_idle();

    // A much smaller interval while a large remainder is still held.
    cfg_write(REG_THRESHOLD, 32'd511);
    cfg_write(REG_INTERVAL, 32'd37);
    add_random_run(150, 10, 60);
    wait_idle();

    cfg_write(REG_INTERVAL, 32'd0);
    add_random_run(100, 0, 4);
    wait_idle();

    cfg_write(REG_THRESHOLD, 32'd512);
    cfg_write(REG_INTERVAL, 32'd414250);
    add_random_run(100, 200_000, 600_000);
    wait_idle();

    repeat (50) @(posedge clk);
    if (track_results_q.size() != 0) begin
      $error("%0d expected result items never arrived", track_results_q.size());
      mismatches++;
    end
    $display("Run covered %0d samples, %0d with a phase change, over %0d register writes.",
             n_items, n_changes, n_cfg_writes);
    $display("Drive results seen: off %0d, plus %0d, minus %0d; %0d field mismatches.",
             drive_seen[0], drive_seen[1], drive_seen[2], mismatches);
    if (mismatches == 0) begin
      $display("** sidereal_tracking_controller: PASSED **");
    end else begin
      $display("** sidereal_tracking_controller: FAILED **");
    end
    $finish;
  end

endmodule
